### rtl/core/audio_ring_rate_controller_defines.svh
// ----------------------------------------------------------------------------
// Audio ring rate controller - assertion macros
// Shared assertion shorthands for the checker of the rate controller.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RING_RATE_CONTROLLER_DEFINES_SVH
`define AUDIO_RING_RATE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ARRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ARRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/arrc_pkg.sv
// ----------------------------------------------------------------------------
// Audio ring rate controller - package
// Beat types, command and rate codes, and register indices and defaults.
// ----------------------------------------------------------------------------
package arrc_pkg;

  localparam int unsigned DEF_RING_SLOTS = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned RATE_W  = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_RATE_UPDATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK_READY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DMA_DONE    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART     = 2'd3;

  // Rate selector codes.
  localparam logic [RATE_W-1:0] RATE_NOMINAL = 2'd0;
  localparam logic [RATE_W-1:0] RATE_SLOW    = 2'd1;
  localparam logic [RATE_W-1:0] RATE_FAST    = 2'd2;

  // Register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WATER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_RELEASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WATER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUED   = 3'd5;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] RST_HIGH_WATER   = 5'd8;
  localparam logic [LEVEL_W-1:0] RST_HIGH_RELEASE = 5'd6;
  localparam logic [LEVEL_W-1:0] RST_LOW_RELEASE  = 5'd6;
  localparam logic [LEVEL_W-1:0] RST_LOW_WATER    = 5'd4;
  localparam logic [LEVEL_W-1:0] RST_START_LEVEL  = 5'd4;
  localparam logic [LEVEL_W-1:0] RST_MAX_QUEUED   = 5'd12;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             turbo_mode;
    logic             overlay_request;
  } in_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_select;
    logic              accepted;
    logic [SLOT_W-1:0] write_slot;
    logic              dma_start;
    logic              dma_arm;
    logic [SLOT_W-1:0] dma_slot;
    logic              stop_dma;
    logic [SLOT_W-1:0] queued;
  } out_item_t;

endpackage

### rtl/core/audio_ring_rate_controller.sv
// ----------------------------------------------------------------------------
// Audio ring rate controller
// Tracks a ring of audio buffer slots between a producer and a playback DMA,
// runs the rate and drop hysteresis, and hands out slots to the DMA.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Beat contents
//   in        input      in_valid_i/in_ready_o  in_item_t (command, flags)
//   out       output     out_valid_o/out_ready_i out_item_t (one per input)
//   cfg       input      cfg_valid_i/cfg_ready_o register index, 5-bit level
//
// Every input beat yields exactly one output beat. The whole update is one
// pass of compare and increment logic from the accepted beat and the ring
// registers into the result register, so while the output is not stalled
// a beat is taken every cycle and its result follows in the next cycle.
// The input side stays ready while the result register is empty or is being
// emptied in the same cycle; a stalled output holds its beat and stalls input.
// Reset returns the ring to empty with neutral rate and the registers to
// their default levels; a restart command clears the ring but not the levels.
// Configuration writes are always taken and are registered directly.
//
module audio_ring_rate_controller
  import arrc_pkg::*;
#(
  parameter int unsigned RING_SLOTS = DEF_RING_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(RING_SLOTS);
  // Compare width holds both an occupancy and a 5-bit level.
  localparam int unsigned CMP_W = (IDX_W > LEVEL_W) ? IDX_W : LEVEL_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_SLOTS - 1);

  // Next slot round the ring; the ring size need not be a power of two.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
  endfunction

  // Occupancy of the ring, write minus play modulo the ring size.
  function automatic logic [IDX_W-1:0] occ_of(input logic [IDX_W-1:0] wr,
                                              input logic [IDX_W-1:0] rd);
    logic [IDX_W:0] diff;
    diff = {1'b0, wr} - {1'b0, rd};
    if (wr < rd) begin
      diff = diff + (IDX_W+1)'(RING_SLOTS);
    end
    return diff[IDX_W-1:0];
  endfunction

  // Configuration registers.
  logic [LEVEL_W-1:0] high_water_q, high_release_q, low_release_q;
  logic [LEVEL_W-1:0] low_water_q, start_level_q, max_queued_q;

  // Ring state.
  logic [IDX_W-1:0]  write_index_q, write_index_d;
  logic [IDX_W-1:0]  play_index_q, play_index_d;
  logic              dma_running_q, dma_running_d;
  logic              dropping_q, dropping_d;
  logic [RATE_W-1:0] rate_mode_q, rate_mode_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              in_accept;
  logic [IDX_W-1:0]  occ;
  logic [CMP_W-1:0]  occ_c;
  logic [IDX_W-1:0]  occ_after_wr;
  logic [RATE_W-1:0] rate_tmp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_water_q   <= RST_HIGH_WATER;
      high_release_q <= RST_HIGH_RELEASE;
      low_release_q  <= RST_LOW_RELEASE;
      low_water_q    <= RST_LOW_WATER;
      start_level_q  <= RST_START_LEVEL;
      max_queued_q   <= RST_MAX_QUEUED;
    end else if (cfg_valid_i) begin
      // Indices past the register list are taken and ignored.
      unique case (cfg_index_i)
        CFG_HIGH_WATER:   high_water_q   <= cfg_data_i;
        CFG_HIGH_RELEASE: high_release_q <= cfg_data_i;
        CFG_LOW_RELEASE:  low_release_q  <= cfg_data_i;
        CFG_LOW_WATER:    low_water_q    <= cfg_data_i;
        CFG_START_LEVEL:  start_level_q  <= cfg_data_i;
        CFG_MAX_QUEUED:   max_queued_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A new beat may enter whenever the result register is free this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign occ   = occ_of(write_index_q, play_index_q);
  assign occ_c = CMP_W'(occ);
  // Occupancy once a block has been written into the next slot.
  assign occ_after_wr = (occ == LAST_SLOT) ? '0 : occ + 1'b1;

  always_comb begin
    write_index_d = write_index_q;
    play_index_d  = play_index_q;
    dma_running_d = dma_running_q;
    dropping_d    = dropping_q;
    rate_mode_d   = rate_mode_q;
    rate_tmp      = rate_mode_q;
    out_data_d    = '0;

    unique case (in_data_i.command)
      CMD_RATE_UPDATE: begin
        if (in_data_i.turbo_mode) begin
          // Fast-forward: rate is forced neutral and only the drop flag runs.
          rate_mode_d = RATE_NOMINAL;
          if (dropping_q && (occ_c <= CMP_W'(low_water_q))) begin
            dropping_d = 1'b0;
          end else if (!dropping_q && (occ_c >= CMP_W'(max_queued_q))) begin
            dropping_d = 1'b1;
          end
        end else begin
          dropping_d = 1'b0;
          // Release first, then engage; an engage overrides a release.
          if (rate_mode_q == RATE_SLOW) begin
            if (occ_c <= CMP_W'(high_release_q)) begin
              rate_tmp = RATE_NOMINAL;
            end
          end else if (rate_mode_q == RATE_FAST) begin
            if (occ_c >= CMP_W'(low_release_q)) begin
              rate_tmp = RATE_NOMINAL;
            end
          end
          if (occ_c > CMP_W'(high_water_q)) begin
            rate_tmp = RATE_SLOW;
          end else if (occ_c < CMP_W'(low_water_q)) begin
            rate_tmp = RATE_FAST;
          end
          rate_mode_d            = rate_tmp;
          out_data_d.rate_select = rate_tmp;
        end
        // The overlay clears the ring after the rate has been worked out.
        if (in_data_i.overlay_request) begin
          out_data_d.stop_dma = 1'b1;
          write_index_d = '0;
          play_index_d  = '0;
          dma_running_d = 1'b0;
          dropping_d    = 1'b0;
          rate_mode_d   = RATE_NOMINAL;
        end
      end
      CMD_BLOCK_READY: begin
        if (!dropping_q && (occ_c < CMP_W'(max_queued_q))) begin
          out_data_d.accepted   = 1'b1;
          out_data_d.write_slot = SLOT_W'(write_index_q);
          write_index_d         = advance(write_index_q);
          // Priming hands slot 0 to the DMA and moves play on to slot 1.
          if (!dma_running_q &&
              (CMP_W'(occ_after_wr) >= CMP_W'(start_level_q))) begin
            out_data_d.dma_start = 1'b1;
            play_index_d         = advance('0);
            dma_running_d        = 1'b1;
          end
        end
      end
      CMD_DMA_DONE: begin
        out_data_d.dma_arm  = 1'b1;
        out_data_d.dma_slot = SLOT_W'(play_index_q);
        play_index_d        = advance(play_index_q);
      end
      CMD_RESTART: begin
        write_index_d = '0;
        play_index_d  = '0;
        dma_running_d = 1'b0;
        dropping_d    = 1'b0;
        rate_mode_d   = RATE_NOMINAL;
      end
    endcase

    out_data_d.queued = SLOT_W'(occ_of(write_index_d, play_index_d));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_index_q <= '0;
      play_index_q  <= '0;
      dma_running_q <= 1'b0;
      dropping_q    <= 1'b0;
      rate_mode_q   <= RATE_NOMINAL;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        write_index_q <= write_index_d;
        play_index_q  <= play_index_d;
        dma_running_q <= dma_running_d;
        dropping_q    <= dropping_d;
        rate_mode_q   <= rate_mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/arrc_checker.sv
// ----------------------------------------------------------------------------
// Audio ring rate controller - checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_ring_rate_controller_defines.svh"

module arrc_checker
  import arrc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_o
);

  // A stalled result beat stays put.
  `ARRC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result beat changed while stalled")

  // A dropped or absent block reports slot zero.
  `ARRC_ASSERT_IMPL(a_drop_slot, out_valid_o && !out_data_o.accepted, out_data_o.write_slot == '0 && !out_data_o.dma_start, "write slot or DMA start without an accepted block")

  // Priming always hands slot zero to the DMA.
  `ARRC_ASSERT_IMPL(a_prime_slot, out_valid_o && out_data_o.dma_start, out_data_o.dma_slot == '0 && !out_data_o.dma_arm && !out_data_o.stop_dma, "DMA start with a bad slot or mixed event")

  // An overlay stop leaves the ring empty.
  `ARRC_ASSERT_IMPL(a_stop_empty, out_valid_o && out_data_o.stop_dma, out_data_o.queued == '0 && !out_data_o.accepted && !out_data_o.dma_arm, "overlay stop with a non-empty ring")

  // Arming the DMA comes from a dma-done beat alone.
  `ARRC_ASSERT_IMPL(a_arm_alone, out_valid_o && out_data_o.dma_arm, out_data_o.rate_select == RATE_NOMINAL && !out_data_o.accepted, "DMA arm mixed with another event")

endmodule

bind audio_ring_rate_controller arrc_checker u_arrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
